// ----- rtl/core/lgs_pkg.sv -----
// Shared types, constants and helper functions for the LDA Gibbs token sampler.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

	// Store sizes
	localparam int MAX_TOPICS = 64;
	localparam int MAX_WORDS  = 4096;
	localparam int MAX_DOCS   = 1024;
	localparam int MAX_TOKENS = 65536;

	localparam int TOPIC_W = $clog2(MAX_TOPICS);
	localparam int WORD_W  = $clog2(MAX_WORDS);
	localparam int DOC_W   = $clog2(MAX_DOCS);
	localparam int TOK_W   = $clog2(MAX_TOKENS);
	localparam int CNT_W   = 17;

	// Flat store addresses: word-topic is topic-major, doc-topic is doc-major
	localparam int WT_AW  = TOPIC_W + WORD_W;
	localparam int DT_AW  = DOC_W + TOPIC_W;
	localparam int CLR_W  = (WT_AW > DT_AW) ? WT_AW : DT_AW;

	// Field and register widths
	localparam int FUNC_W = 2;
	localparam int NT_W   = 7;
	localparam int VOC_W  = 13;
	localparam int Q_W    = 32;
	localparam int IDX_W  = 2;

	// Arithmetic widths
	localparam int ONE_Q  = 65536;
	localparam int OPND_W = 34;
	localparam int DEN_W  = 46;
	localparam int PROD_W = 2 * OPND_W;
	localparam int HI_W   = PROD_W - 48;
	localparam int QUO_W  = 64;
	localparam int WB_W   = VOC_W + Q_W;
	localparam int TA_W   = NT_W + Q_W;
	localparam int SUM_W  = Q_W + TOPIC_W;
	localparam int THR_W  = SUM_W + 1;
	localparam int STEP_W = 6;
	localparam int MUL_STEPS = OPND_W;
	localparam int DIV_STEPS = QUO_W;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W        = $clog2(QUEUE_DEPTH);

	typedef enum logic [IDX_W-1:0] {
		REG_ALPHA = 2'd0,
		REG_BETA  = 2'd1,
		REG_NTOP  = 2'd2,
		REG_VOCAB = 2'd3
	} cfg_reg_t;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLEAR    = 2'd0,
		FUNC_LOAD     = 2'd1,
		FUNC_RESAMPLE = 2'd2,
		FUNC_NONE     = 2'd3
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [TOK_W-1:0]   tok;
		logic [WORD_W-1:0]  word;
		logic [DOC_W-1:0]   doc;
		logic [TOPIC_W-1:0] topic;
		logic [Q_W-1:0]     u;
		logic [NT_W-1:0]    ntop;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qsts_t;

	typedef struct packed {
		logic init_clr;
	} bk_sts_t;

	typedef struct packed {
		logic              go;
		logic              plain_div;
		logic [OPND_W-1:0] a;
		logic [OPND_W-1:0] b;
		logic [DEN_W-1:0]  d;
		logic [QUO_W-1:0]  n;
	} mdu_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] q;
	} mdu_rsp_t;

	// Topic count in use: zero acts as one, anything above the maximum as the maximum.
	function automatic logic [NT_W-1:0] eff_topics(input logic [NT_W-1:0] n);
		logic [NT_W-1:0] r;
		r = n;
		if (n == '0)
			r = NT_W'(1);
		else if (n > NT_W'(MAX_TOPICS))
			r = NT_W'(MAX_TOPICS);
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lgs_front.sv -----
// Front end of the sampler: takes command transactions and classifies them.
// Depends on lgs_pkg; feeds lgs_queue.
`timescale 1ns / 1ps
`default_nettype none

module lgs_front (
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [lgs_pkg::FUNC_W-1:0]  func,
	input  wire logic [lgs_pkg::TOK_W-1:0]   token_index,
	input  wire logic [lgs_pkg::WORD_W-1:0]  word_index,
	input  wire logic [lgs_pkg::DOC_W-1:0]   doc_index,
	input  wire logic [lgs_pkg::TOPIC_W-1:0] initial_topic,
	input  wire logic [lgs_pkg::Q_W-1:0]     uniform_random,
	input  wire logic [lgs_pkg::NT_W-1:0]    num_topics,
	input  wire lgs_pkg::qsts_t              qsts,
	input  wire lgs_pkg::bk_sts_t            bsts,
	output logic                             push,
	output lgs_pkg::item_t                   item
);

	logic [lgs_pkg::NT_W-1:0] t_eff;
	logic [lgs_pkg::NT_W-1:0] t_last;

	// Hold off new transactions while the queue is full or the stores are
	// still being cleared after reset.
	assign busy = qsts.full || bsts.init_clr;
	assign push = start && !busy;

	assign t_eff  = lgs_pkg::eff_topics(num_topics);
	assign t_last = t_eff - lgs_pkg::NT_W'(1);

	// Classify the command and clamp a load topic into the active range.
	always_comb begin
		item.func = lgs_pkg::func_t'(func);
		item.tok  = token_index;
		item.word = word_index;
		item.doc  = doc_index;
		item.u    = uniform_random;
		item.ntop = t_eff;
		if ({1'b0, initial_topic} < t_eff)
			item.topic = initial_topic;
		else
			item.topic = t_last[lgs_pkg::TOPIC_W-1:0];
	end

endmodule

`default_nettype wire

// ----- rtl/core/lgs_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on lgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgs_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire lgs_pkg::item_t item_in,
	input  wire logic           pop,
	output lgs_pkg::item_t      head,
	output lgs_pkg::qsts_t      qsts
);

	lgs_pkg::item_t            slot_q [lgs_pkg::QUEUE_DEPTH];
	logic [lgs_pkg::QP_W-1:0]  wr_ptr_q;
	logic [lgs_pkg::QP_W-1:0]  rd_ptr_q;
	logic [lgs_pkg::QP_W:0]    count_q;

	assign qsts.full  = (count_q == (lgs_pkg::QP_W+1)'(lgs_pkg::QUEUE_DEPTH));
	assign qsts.empty = (count_q == '0);
	assign head       = slot_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + lgs_pkg::QP_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + lgs_pkg::QP_W'(1);
			if (push && !pop)
				count_q <= count_q + (lgs_pkg::QP_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (lgs_pkg::QP_W+1)'(1);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= item_in;
	end

endmodule

`default_nettype wire

// ----- rtl/core/lgs_mdu.sv -----
// Serial multiply-divide unit: floor(a*b*2^16/d) saturated to 64 bits,
// or a plain 64-bit by d division. Depends on lgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgs_mdu (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lgs_pkg::mdu_req_t req,
	output lgs_pkg::mdu_rsp_t     rsp
);

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_MUL  = 4'b0010,
		M_CHK  = 4'b0100,
		M_DIV  = 4'b1000
	} mstate_t;

	mstate_t                          state_q;
	logic [lgs_pkg::STEP_W-1:0]       cnt_q;
	logic [lgs_pkg::PROD_W-1:0]       prod_q;
	logic [lgs_pkg::OPND_W-1:0]       a_q;
	logic [lgs_pkg::DEN_W-1:0]        d_q;
	logic [lgs_pkg::DEN_W-1:0]        r_q;
	logic [lgs_pkg::QUO_W-1:0]        lo_q;
	logic                             done_q;

	logic [lgs_pkg::OPND_W:0]         mul_sum;
	logic [lgs_pkg::DEN_W:0]          r_shift;
	logic                             r_ge;
	logic [lgs_pkg::DEN_W:0]          r_diff;
	logic [lgs_pkg::HI_W-1:0]         prod_hi;

	assign rsp.done = done_q;
	assign rsp.q    = lo_q;

	// One shift-add multiply step and one restoring divide step
	always_comb begin
		mul_sum = {1'b0, prod_q[lgs_pkg::PROD_W-1:lgs_pkg::OPND_W]}
			+ (prod_q[0] ? {1'b0, a_q} : '0);
		r_shift = {r_q, lo_q[lgs_pkg::QUO_W-1]};
		r_ge    = (r_shift >= {1'b0, d_q});
		r_diff  = r_shift - {1'b0, d_q};
		prod_hi = prod_q[lgs_pkg::PROD_W-1:lgs_pkg::PROD_W-lgs_pkg::HI_W];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					cnt_q <= '0;
					if (req.go)
						state_q <= req.plain_div ? M_DIV : M_MUL;
				end
				M_MUL: begin
					cnt_q <= cnt_q + lgs_pkg::STEP_W'(1);
					if (cnt_q == lgs_pkg::STEP_W'(lgs_pkg::MUL_STEPS - 1))
						state_q <= M_CHK;
				end
				M_CHK: begin
					cnt_q <= '0;
					if ({{(lgs_pkg::DEN_W-lgs_pkg::HI_W){1'b0}}, prod_hi} >= d_q) begin
						state_q <= M_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= M_DIV;
					end
				end
				M_DIV: begin
					cnt_q <= cnt_q + lgs_pkg::STEP_W'(1);
					if (cnt_q == lgs_pkg::STEP_W'(lgs_pkg::DIV_STEPS - 1)) begin
						state_q <= M_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			M_IDLE: begin
				if (req.go) begin
					a_q    <= req.a;
					d_q    <= req.d;
					prod_q <= {{lgs_pkg::OPND_W{1'b0}}, req.b};
					r_q    <= '0;
					lo_q   <= req.n;
				end
			end
			M_MUL: begin
				prod_q <= {mul_sum, prod_q[lgs_pkg::OPND_W-1:1]};
			end
			M_CHK: begin
				// Quotient would not fit in 64 bits: saturate
				if ({{(lgs_pkg::DEN_W-lgs_pkg::HI_W){1'b0}}, prod_hi} >= d_q) begin
					lo_q <= '1;
				end else begin
					r_q  <= {{(lgs_pkg::DEN_W-lgs_pkg::HI_W){1'b0}}, prod_hi};
					lo_q <= {prod_q[lgs_pkg::PROD_W-lgs_pkg::HI_W-1:0], 16'b0};
				end
			end
			M_DIV: begin
				r_q  <= r_ge ? r_diff[lgs_pkg::DEN_W-1:0] : r_shift[lgs_pkg::DEN_W-1:0];
				lo_q <= {lo_q[lgs_pkg::QUO_W-2:0], r_ge};
			end
			default: begin
				r_q <= r_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/lgs_back.sv -----
// Back end of the sampler: count stores, clear sweep, load, and the resample
// sequencer that drives the shared multiply-divide unit. Depends on lgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgs_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [lgs_pkg::Q_W-1:0]       alpha_prior,
	input  wire logic [lgs_pkg::Q_W-1:0]       beta_prior,
	input  wire logic [lgs_pkg::VOC_W-1:0]     vocab_size,
	input  wire lgs_pkg::item_t                head,
	input  wire lgs_pkg::qsts_t                qsts,
	output logic                               pop,
	output lgs_pkg::bk_sts_t                   bsts,
	output lgs_pkg::mdu_req_t                  mreq,
	input  wire lgs_pkg::mdu_rsp_t             mrsp,
	output logic                               done,
	output logic [lgs_pkg::TOPIC_W-1:0]        new_topic,
	output logic [lgs_pkg::Q_W-1:0]            likelihood_term
);

	typedef enum logic [19:0] {
		B_IDLE   = 20'h00001,
		B_CLR    = 20'h00002,
		B_LD_RD  = 20'h00004,
		B_LD_WR  = 20'h00008,
		B_RS_TOK = 20'h00010,
		B_RS_Z   = 20'h00020,
		B_RM_RD  = 20'h00040,
		B_RM_WR  = 20'h00080,
		B_RS_DB  = 20'h00100,
		B_SC_RD  = 20'h00200,
		B_SC_OPS = 20'h00400,
		B_SC_A   = 20'h00800,
		B_SC_A2  = 20'h01000,
		B_SC_LIK = 20'h02000,
		B_TH1    = 20'h04000,
		B_TH2    = 20'h08000,
		B_PK_RD  = 20'h10000,
		B_PK_CMP = 20'h20000,
		B_AD_RD  = 20'h40000,
		B_AD_WR  = 20'h80000
	} bstate_t;

	bstate_t                            state_q;
	lgs_pkg::item_t                     it_q;
	logic                               cmd_clr_q;
	logic [lgs_pkg::CLR_W-1:0]          clr_q;
	logic [lgs_pkg::TOPIC_W-1:0]        cur_topic_q;
	logic [lgs_pkg::TOPIC_W-1:0]        t_q;
	logic [lgs_pkg::CNT_W-1:0]          ds_rm_q;
	logic [lgs_pkg::WB_W-1:0]           wb_q;
	logic [lgs_pkg::TA_W-1:0]           ta_q;
	logic [lgs_pkg::DEN_W-1:0]          db_q;
	logic [lgs_pkg::OPND_W-1:0]         n1_q;
	logic [lgs_pkg::OPND_W-1:0]         n2_q;
	logic [lgs_pkg::DEN_W-1:0]          da_q;
	logic [lgs_pkg::SUM_W-1:0]          sum_q;
	logic [lgs_pkg::Q_W-1:0]            lik_q;
	logic [63:0]                        p_lo_q;
	logic [lgs_pkg::SUM_W-1:0]          p_hi_q;
	logic [lgs_pkg::THR_W-1:0]          thr_q;
	logic [lgs_pkg::SUM_W-1:0]          cum_q;
	logic                               done_q;
	logic [lgs_pkg::TOPIC_W-1:0]        topic_out_q;
	logic [lgs_pkg::Q_W-1:0]            lik_out_q;

	// Stores
	logic [lgs_pkg::CNT_W-1:0]   wt_mem  [1 << lgs_pkg::WT_AW];
	logic [lgs_pkg::CNT_W-1:0]   dt_mem  [1 << lgs_pkg::DT_AW];
	logic [lgs_pkg::CNT_W-1:0]   tt_mem  [lgs_pkg::MAX_TOPICS];
	logic [lgs_pkg::CNT_W-1:0]   ds_mem  [lgs_pkg::MAX_DOCS];
	logic [lgs_pkg::TOPIC_W-1:0] tok_mem [lgs_pkg::MAX_TOKENS];
	logic [lgs_pkg::Q_W-1:0]     wbf_mem [lgs_pkg::MAX_TOPICS];

	logic [lgs_pkg::CNT_W-1:0]   wt_rd_q, dt_rd_q, tt_rd_q, ds_rd_q;
	logic [lgs_pkg::TOPIC_W-1:0] tok_rd_q;
	logic [lgs_pkg::Q_W-1:0]     wbf_rd_q;

	logic [lgs_pkg::TOPIC_W-1:0] rd_topic;
	logic                        cnt_we;
	logic                        tok_we;
	logic                        clr_we;
	logic [lgs_pkg::CNT_W-1:0]   delta;
	logic [lgs_pkg::WT_AW-1:0]   wt_wa;
	logic [lgs_pkg::DT_AW-1:0]   dt_wa;
	logic [lgs_pkg::TOPIC_W-1:0] tt_wa;
	logic [lgs_pkg::DOC_W-1:0]   ds_wa;
	logic [lgs_pkg::CNT_W-1:0]   wt_wd, dt_wd, tt_wd, ds_wd;

	logic                        t_last;
	logic [lgs_pkg::OPND_W-1:0]  n1_c, n2_c;
	logic [lgs_pkg::DEN_W-1:0]   da_sum, da_c;
	logic [lgs_pkg::Q_W-1:0]     weight_c;
	logic [lgs_pkg::Q_W:0]       lik_sum;
	logic [lgs_pkg::Q_W-1:0]     lik_c;
	logic [lgs_pkg::SUM_W-1:0]   cum_c;
	logic [lgs_pkg::NT_W-1:0]    ntop_last;

	assign bsts.init_clr  = (state_q == B_CLR) && !cmd_clr_q;
	assign pop            = (state_q == B_IDLE) && !qsts.empty;
	assign done           = done_q;
	assign new_topic      = topic_out_q;
	assign likelihood_term = lik_out_q;

	// Per-topic operands and the running sums
	always_comb begin
		ntop_last = it_q.ntop - lgs_pkg::NT_W'(1);
		t_last    = ({1'b0, t_q} == ntop_last);
		n1_c      = {1'b0, wt_rd_q, 16'b0} + {2'b0, beta_prior};
		n2_c      = {1'b0, dt_rd_q, 16'b0} + {2'b0, alpha_prior};
		da_sum    = {13'b0, tt_rd_q, 16'b0} + {1'b0, wb_q};
		da_c      = (da_sum == '0) ? lgs_pkg::DEN_W'(1) : da_sum;
		weight_c  = (mrsp.q[63:48] != '0) ? '1 : mrsp.q[47:16];
		lik_sum   = {1'b0, lik_q} + {1'b0, mrsp.q[31:0]};
		lik_c     = ((mrsp.q[63:32] != '0) || lik_sum[lgs_pkg::Q_W])
			? '1 : lik_sum[lgs_pkg::Q_W-1:0];
		cum_c     = cum_q + lgs_pkg::SUM_W'(wbf_rd_q);
	end

	// Requests to the multiply-divide unit
	always_comb begin
		mreq = '0;
		unique case (state_q)
			B_SC_OPS: begin
				mreq.go = 1'b1;
				mreq.a  = n1_c;
				mreq.b  = n2_c;
				mreq.d  = da_c;
			end
			B_SC_A: begin
				if (mrsp.done) begin
					mreq.go = 1'b1;
					if (t_q == cur_topic_q) begin
						// Old topic: the term uses the counts with the token put back
						mreq.a = n1_q + lgs_pkg::OPND_W'(lgs_pkg::ONE_Q);
						mreq.b = n2_q + lgs_pkg::OPND_W'(lgs_pkg::ONE_Q);
						mreq.d = da_q + lgs_pkg::DEN_W'(lgs_pkg::ONE_Q);
					end else begin
						mreq.plain_div = 1'b1;
						mreq.n         = mrsp.q;
						mreq.d         = db_q;
					end
				end
			end
			B_SC_A2: begin
				if (mrsp.done) begin
					mreq.go        = 1'b1;
					mreq.plain_div = 1'b1;
					mreq.n         = mrsp.q;
					mreq.d         = db_q;
				end
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	// Store addressing and write data
	always_comb begin
		rd_topic = (state_q == B_SC_RD) ? t_q : cur_topic_q;
		clr_we   = (state_q == B_CLR);
		cnt_we   = (state_q == B_LD_WR) || (state_q == B_RM_WR) || (state_q == B_AD_WR);
		tok_we   = (state_q == B_LD_WR) || (state_q == B_AD_WR);
		delta    = (state_q == B_RM_WR) ? '1 : lgs_pkg::CNT_W'(1);
		if (clr_we) begin
			wt_wa = clr_q[lgs_pkg::WT_AW-1:0];
			dt_wa = clr_q[lgs_pkg::DT_AW-1:0];
			tt_wa = clr_q[lgs_pkg::TOPIC_W-1:0];
			ds_wa = clr_q[lgs_pkg::DOC_W-1:0];
			wt_wd = '0;
			dt_wd = '0;
			tt_wd = '0;
			ds_wd = '0;
		end else begin
			wt_wa = {cur_topic_q, it_q.word};
			dt_wa = {it_q.doc, cur_topic_q};
			tt_wa = cur_topic_q;
			ds_wa = it_q.doc;
			wt_wd = wt_rd_q + delta;
			dt_wd = dt_rd_q + delta;
			tt_wd = tt_rd_q + delta;
			ds_wd = ds_rd_q + delta;
		end
	end

	// Count stores: one write and one registered read a cycle each
	always_ff @(posedge clk) begin
		if (clr_we || cnt_we) begin
			wt_mem[wt_wa] <= wt_wd;
			dt_mem[dt_wa] <= dt_wd;
			tt_mem[tt_wa] <= tt_wd;
			ds_mem[ds_wa] <= ds_wd;
		end
		wt_rd_q <= wt_mem[{rd_topic, it_q.word}];
		dt_rd_q <= dt_mem[{it_q.doc, rd_topic}];
		tt_rd_q <= tt_mem[rd_topic];
		ds_rd_q <= ds_mem[it_q.doc];
	end

	// Token topic store; the clearing pass zeroes it along with the counts.
	always_ff @(posedge clk) begin
		if (clr_we)
			tok_mem[clr_q[lgs_pkg::TOK_W-1:0]] <= '0;
		else if (tok_we)
			tok_mem[it_q.tok] <= cur_topic_q;
		tok_rd_q <= tok_mem[it_q.tok];
	end

	// Weight buffer for the selection pass
	always_ff @(posedge clk) begin
		if ((state_q == B_SC_A) && mrsp.done)
			wbf_mem[t_q] <= weight_c;
		wbf_rd_q <= wbf_mem[t_q];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLR;
			cmd_clr_q <= 1'b0;
			clr_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					clr_q <= '0;
					if (!qsts.empty) begin
						unique case (head.func)
							lgs_pkg::FUNC_CLEAR: begin
								cmd_clr_q <= 1'b1;
								state_q   <= B_CLR;
							end
							lgs_pkg::FUNC_LOAD:     state_q <= B_LD_RD;
							lgs_pkg::FUNC_RESAMPLE: state_q <= B_RS_TOK;
							lgs_pkg::FUNC_NONE:     done_q  <= 1'b1;
							default:                state_q <= B_IDLE;
						endcase
					end
				end
				B_CLR: begin
					clr_q <= clr_q + lgs_pkg::CLR_W'(1);
					if (clr_q == '1) begin
						done_q    <= cmd_clr_q;
						cmd_clr_q <= 1'b0;
						state_q   <= B_IDLE;
					end
				end
				B_LD_RD:  state_q <= B_LD_WR;
				B_LD_WR: begin
					done_q  <= 1'b1;
					state_q <= B_IDLE;
				end
				B_RS_TOK: state_q <= B_RS_Z;
				B_RS_Z:   state_q <= B_RM_RD;
				B_RM_RD:  state_q <= B_RM_WR;
				B_RM_WR:  state_q <= B_RS_DB;
				B_RS_DB:  state_q <= B_SC_RD;
				B_SC_RD:  state_q <= B_SC_OPS;
				B_SC_OPS: state_q <= B_SC_A;
				B_SC_A: begin
					if (mrsp.done)
						state_q <= (t_q == cur_topic_q) ? B_SC_A2 : B_SC_LIK;
				end
				B_SC_A2: begin
					if (mrsp.done)
						state_q <= B_SC_LIK;
				end
				B_SC_LIK: begin
					if (mrsp.done)
						state_q <= t_last ? B_TH1 : B_SC_RD;
				end
				B_TH1:    state_q <= B_TH2;
				B_TH2:    state_q <= B_PK_RD;
				B_PK_RD:  state_q <= B_PK_CMP;
				B_PK_CMP: begin
					if (({1'b0, cum_c} > thr_q) || t_last)
						state_q <= B_AD_RD;
					else
						state_q <= B_PK_RD;
				end
				B_AD_RD:  state_q <= B_AD_WR;
				B_AD_WR: begin
					done_q  <= 1'b1;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Datapath registers of the current transaction
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (!qsts.empty) begin
					it_q        <= head;
					cur_topic_q <= head.topic;
					topic_out_q <= '0;
					lik_out_q   <= '0;
				end
			end
			B_CLR: begin
				topic_out_q <= '0;
				lik_out_q   <= '0;
			end
			B_LD_WR: begin
				topic_out_q <= cur_topic_q;
				lik_out_q   <= '0;
			end
			B_RS_Z: begin
				cur_topic_q <= tok_rd_q;
			end
			B_RM_WR: begin
				ds_rm_q <= ds_rd_q - lgs_pkg::CNT_W'(1);
				wb_q    <= vocab_size * beta_prior;
				ta_q    <= it_q.ntop * alpha_prior;
				t_q     <= '0;
				sum_q   <= '0;
				lik_q   <= '0;
			end
			B_RS_DB: begin
				db_q <= lgs_pkg::DEN_W'({({1'b0, ds_rm_q} + (lgs_pkg::CNT_W+1)'(1)), 16'b0})
					+ lgs_pkg::DEN_W'(ta_q);
			end
			B_SC_OPS: begin
				n1_q <= n1_c;
				n2_q <= n2_c;
				da_q <= da_c;
			end
			B_SC_A: begin
				if (mrsp.done)
					sum_q <= sum_q + lgs_pkg::SUM_W'(weight_c);
			end
			B_SC_LIK: begin
				if (mrsp.done) begin
					lik_q <= lik_c;
					if (!t_last)
						t_q <= t_q + lgs_pkg::TOPIC_W'(1);
				end
			end
			B_TH1: begin
				// Scale the weight sum by the uniform fraction in two partial products
				p_lo_q <= sum_q[lgs_pkg::Q_W-1:0] * it_q.u;
				p_hi_q <= sum_q[lgs_pkg::SUM_W-1:lgs_pkg::Q_W] * it_q.u;
			end
			B_TH2: begin
				thr_q <= {1'b0, p_hi_q} + lgs_pkg::THR_W'(p_lo_q[63:32]);
				cum_q <= '0;
				t_q   <= '0;
			end
			B_PK_CMP: begin
				cum_q <= cum_c;
				if (({1'b0, cum_c} > thr_q) || t_last)
					cur_topic_q <= t_q;
				else
					t_q <= t_q + lgs_pkg::TOPIC_W'(1);
			end
			B_AD_WR: begin
				topic_out_q <= cur_topic_q;
				lik_out_q   <= lik_q;
			end
			default: begin
				it_q <= it_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/lda_gibbs_token_sampler.sv -----
// Top level of the LDA collapsed Gibbs token sampler: configuration registers,
// front end, command queue, back end and multiply-divide unit. Depends on lgs_pkg.
//
// Channel   | Signals                                         | Transaction when
// ----------+-------------------------------------------------+--------------------------
// command   | start, busy, func, token/word/doc indices, ... | start high, busy low
// result    | done, new_topic, likelihood_term                | done high (one cycle)
// config    | cfg_write, cfg_index, cfg_data                  | cfg_write high
//
// A resample walks the topics one at a time through one shared serial
// multiply-divide unit, with one more multiply-divide pass for the token's old
// topic. After reset a clearing pass holds busy high. Results cannot be
// stalled; the queue lets two further commands wait while the back end works.
`timescale 1ns / 1ps
`default_nettype none

module lda_gibbs_token_sampler (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [lgs_pkg::FUNC_W-1:0]  func,
	input  wire logic [lgs_pkg::TOK_W-1:0]   token_index,
	input  wire logic [lgs_pkg::WORD_W-1:0]  word_index,
	input  wire logic [lgs_pkg::DOC_W-1:0]   doc_index,
	input  wire logic [lgs_pkg::TOPIC_W-1:0] initial_topic,
	input  wire logic [lgs_pkg::Q_W-1:0]     uniform_random,
	output logic                             done,
	output logic [lgs_pkg::TOPIC_W-1:0]      new_topic,
	output logic [lgs_pkg::Q_W-1:0]          likelihood_term,
	input  wire logic                        cfg_write,
	input  wire logic [lgs_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [lgs_pkg::Q_W-1:0]     cfg_data
);

	logic [lgs_pkg::Q_W-1:0]   alpha_q;
	logic [lgs_pkg::Q_W-1:0]   beta_q;
	logic [lgs_pkg::NT_W-1:0]  ntop_q;
	logic [lgs_pkg::VOC_W-1:0] vocab_q;

	lgs_pkg::qsts_t    qsts;
	lgs_pkg::bk_sts_t  bsts;
	lgs_pkg::item_t    item;
	lgs_pkg::item_t    head;
	lgs_pkg::mdu_req_t mreq;
	lgs_pkg::mdu_rsp_t mrsp;
	logic              push;
	logic              pop;
	logic [lgs_pkg::NT_W-1:0] t_eff;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= lgs_pkg::Q_W'(6554);
			beta_q  <= lgs_pkg::Q_W'(655);
			ntop_q  <= lgs_pkg::NT_W'(64);
			vocab_q <= lgs_pkg::VOC_W'(4096);
		end else if (cfg_write) begin
			unique case (lgs_pkg::cfg_reg_t'(cfg_index))
				lgs_pkg::REG_ALPHA: alpha_q <= cfg_data;
				lgs_pkg::REG_BETA:  beta_q  <= cfg_data;
				lgs_pkg::REG_NTOP:  ntop_q  <= cfg_data[lgs_pkg::NT_W-1:0];
				lgs_pkg::REG_VOCAB: vocab_q <= cfg_data[lgs_pkg::VOC_W-1:0];
				default:            alpha_q <= alpha_q;
			endcase
		end
	end

	lgs_front u_front (
		.start          (start),
		.busy           (busy),
		.func           (func),
		.token_index    (token_index),
		.word_index     (word_index),
		.doc_index      (doc_index),
		.initial_topic  (initial_topic),
		.uniform_random (uniform_random),
		.num_topics     (ntop_q),
		.qsts           (qsts),
		.bsts           (bsts),
		.push           (push),
		.item           (item)
	);

	lgs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item_in (item),
		.pop     (pop),
		.head    (head),
		.qsts    (qsts)
	);

	lgs_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	lgs_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.alpha_prior     (alpha_q),
		.beta_prior      (beta_q),
		.vocab_size      (vocab_q),
		.head            (head),
		.qsts            (qsts),
		.pop             (pop),
		.bsts            (bsts),
		.mreq            (mreq),
		.mrsp            (mrsp),
		.done            (done),
		.new_topic       (new_topic),
		.likelihood_term (likelihood_term)
	);

	assign t_eff = lgs_pkg::eff_topics(ntop_q);

	// A result never carries unknown bits.
	a_done_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({new_topic, likelihood_term}))
		else $error("result carries unknown bits");

	// A reported topic is always inside the active topic range.
	a_topic_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ({1'b0, new_topic} < t_eff))
		else $error("result topic outside the active range");

	// The clearing pass after reset produces no result.
	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		bsts.init_clr |-> !done)
		else $error("result during the clearing pass after reset");

endmodule

`default_nettype wire
